### hdl/icr_pkg.sv
// ----------------------------------------------------------------------------
// icr_pkg
// Shared constants, register codes and item types for the impulse collision
// response pipeline.
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int WORD_BITS      = 32;
  localparam int FRAC_BITS      = 16;
  localparam int MASS_BITS      = 31;
  localparam int COEF_BITS      = 17;
  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OWN_MASS  = 3'd0,
    REG_OWN_DYN   = 3'd1,
    REG_REST      = 3'd2,
    REG_FRIC      = 3'd3,
    REG_SEP       = 3'd4
  } cfg_reg_t;

  localparam logic [MASS_BITS-1:0] OWN_MASS_RST = 31'd65536;
  localparam logic [COEF_BITS-1:0] REST_RST     = 17'd32768;
  localparam logic [COEF_BITS-1:0] FRIC_RST     = 17'd32768;
  localparam logic [MASS_BITS-1:0] SEP_RST      = 31'd6554;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [31:0] s32_t;

  typedef struct {
    logic              go;
    logic [30:0]       m2;
    s32_t              n    [3];
    s32_t              u    [3];
    s32_t              p    [3];
    logic signed [32:0] r   [3];
    s32_t              push [3];
    logic signed [49:0] a   [3];
    logic signed [50:0] vn;
    logic signed [51:0] k;
    logic [63:0]       nvlo [3];
    logic [49:0]       nvhi [3];
    logic              nvneg[3];
    s64_t              nvn  [3];
    s64_t              t    [3];
    logic              tz;
    logic [48:0]       flo  [3];
    logic [48:0]       fhi  [3];
    logic              fneg [3];
    s64_t              f    [3];
    logic [79:0]       num1 [3];
    logic [79:0]       num2 [3];
    logic              ovf1 [3];
    logic              ovf2 [3];
    logic signed [51:0] d1;
    logic signed [51:0] d2;
    logic [63:0]       nd1lo[3];
    logic [51:0]       nd1hi[3];
    logic              nd1ng[3];
    logic [63:0]       nd2lo[3];
    logic [51:0]       nd2hi[3];
    logic              nd2ng[3];
    s64_t              nd1  [3];
    s64_t              nd2  [3];
    s64_t              u1   [3];
    s64_t              p1   [3];
    s64_t              fd1  [3];
    s64_t              fd2  [3];
  } icr_item_t;

  typedef struct packed {
    logic [2:0][31:0] own;
    logic [2:0][31:0] peer;
    logic [2:0][31:0] push;
    logic             resolved;
  } icr_out_t;

endpackage

### hdl/icr_div.sv
// ----------------------------------------------------------------------------
// icr_div
// Pipelined restoring divider, a few quotient bits per stage. The upper part
// of the dividend must be below the divisor so that the quotient fits.
// ----------------------------------------------------------------------------
module icr_div #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 31,
  parameter int QW    = 63,
  parameter int BPS   = 3
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quo,
  output logic [DEN_W-1:0] rem
);

  localparam int NS = (QW + BPS - 1) / BPS;

  logic [DEN_W-1:0] rem_r   [NS];
  logic [QW-1:0]    x_r     [NS];
  logic [DEN_W-1:0] den_r   [NS];
  logic [DEN_W-1:0] rem_nxt [NS];
  logic [QW-1:0]    x_nxt   [NS];
  logic [DEN_W-1:0] den_nxt [NS];

  always_comb begin
    logic [DEN_W-1:0] rv;
    logic [QW-1:0]    xv;
    logic [DEN_W-1:0] dv;
    logic [DEN_W:0]   tr;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rv = DEN_W'(num[NUM_W-1:QW]);
        xv = num[QW-1:0];
        dv = den;
      end else begin
        rv = rem_r[s-1];
        xv = x_r[s-1];
        dv = den_r[s-1];
      end
      for (int b = 0; b < BPS; b++) begin
        if (s * BPS + b < QW) begin
          tr = {rv, xv[QW-1]};
          xv = {xv[QW-2:0], 1'b0};
          if (tr >= {1'b0, dv}) begin
            tr    = tr - {1'b0, dv};
            xv[0] = 1'b1;
          end
          rv = tr[DEN_W-1:0];
        end
      end
      rem_nxt[s] = rv;
      x_nxt[s]   = xv;
      den_nxt[s] = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        x_r[s]   <= x_nxt[s];
        den_r[s] <= den_nxt[s];
      end
    end
  end

  assign quo = x_r[NS-1];
  assign rem = rem_r[NS-1];

endmodule

### hdl/impulse_collision_response.sv
// ----------------------------------------------------------------------------
// impulse_collision_response
// Resolves one contact per item: restitution impulse over inverse masses,
// friction along the tangent and a fixed push along the normal, Q16.16.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    normal, both velocities, peer mass
//  out_      output     out_valid/out_ready  new velocities, push, resolved
//  cfg_      input      cfg_we               cfg_index, cfg_data
//
//  one item per cycle sustained while the output skid slot is empty
//  most of the pipeline is the 63-bit friction dividers, 21 stages of 3 bits each
//  reset is synchronous: clears stage and output valid bits, presets registers
//  a stall freezes the whole pipeline only once the output skid slot is full
// ----------------------------------------------------------------------------
module impulse_collision_response (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [icr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [icr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_normal_x,
  input  logic signed [31:0] in_normal_y,
  input  logic signed [31:0] in_normal_z,
  input  logic signed [31:0] in_own_vel_x,
  input  logic signed [31:0] in_own_vel_y,
  input  logic signed [31:0] in_own_vel_z,
  input  logic signed [31:0] in_peer_vel_x,
  input  logic signed [31:0] in_peer_vel_y,
  input  logic signed [31:0] in_peer_vel_z,
  input  logic [30:0] in_peer_mass,
  input  logic        in_peer_is_static,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_new_own_vel_x,
  output logic signed [31:0] out_new_own_vel_y,
  output logic signed [31:0] out_new_own_vel_z,
  output logic signed [31:0] out_new_peer_vel_x,
  output logic signed [31:0] out_new_peer_vel_y,
  output logic signed [31:0] out_new_peer_vel_z,
  output logic signed [31:0] out_push_x,
  output logic signed [31:0] out_push_y,
  output logic signed [31:0] out_push_z,
  output logic        out_resolved
);

  localparam int FDIV_QW     = 63;
  localparam int FDIV_BPS    = 3;
  localparam int FDIV_STAGES = (FDIV_QW + FDIV_BPS - 1) / FDIV_BPS;
  localparam int WDIV_QW     = 16;
  localparam int WDIV_BPS    = 2;
  localparam int ST_FEED     = (WDIV_QW + WDIV_BPS - 1) / WDIV_BPS;
  localparam int ST_FDONE    = ST_FEED + FDIV_STAGES;
  localparam int NSTG        = ST_FDONE + 2;

  localparam icr_pkg::s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam icr_pkg::s64_t S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [79:0]   MAG_LIM = 80'h0000_8000_0000_0000_0000;

  function automatic icr_pkg::s64_t from_mag(input logic neg, input logic [79:0] m);
    icr_pkg::s64_t res;
    if (neg) begin
      res = (m >= MAG_LIM) ? S64_MIN : icr_pkg::s64_t'(~m[63:0] + 64'd1);
    end else begin
      res = (m >= MAG_LIM) ? S64_MAX : icr_pkg::s64_t'(m[63:0]);
    end
    return res;
  endfunction

  function automatic logic [63:0] mag64(input icr_pkg::s64_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic [31:0] abs32(input icr_pkg::s32_t a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic icr_pkg::s64_t sadd(input icr_pkg::s64_t a, input icr_pkg::s64_t b);
    logic [64:0]   s;
    icr_pkg::s64_t res;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) res = s[64] ? S64_MIN : S64_MAX;
    else res = s[63:0];
    return res;
  endfunction

  function automatic icr_pkg::s64_t ssub(input icr_pkg::s64_t a, input icr_pkg::s64_t b);
    logic [64:0]   s;
    icr_pkg::s64_t res;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) res = s[64] ? S64_MIN : S64_MAX;
    else res = s[63:0];
    return res;
  endfunction

  function automatic logic [31:0] clamp32(input icr_pkg::s64_t v);
    logic [31:0] res;
    if ((&v[63:31]) || !(|v[63:31])) res = v[31:0];
    else res = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return res;
  endfunction

  // configuration registers
  logic [30:0] own_mass_r;
  logic        own_dyn_r;
  logic [16:0] rest_r;
  logic [16:0] fric_r;
  logic [30:0] sep_r;
  logic [30:0] m1;

  icr_pkg::icr_item_t st_r   [NSTG];
  icr_pkg::icr_item_t st_nxt [NSTG];
  logic [NSTG-1:0]    v_r;
  logic               en;

  logic [15:0] wq;
  logic [31:0] wrem;
  logic [62:0] q1 [3];
  logic [62:0] q2 [3];

  icr_pkg::icr_out_t res, a_r, b_r;
  logic              a_v_r, b_v_r;

  assign m1       = (own_mass_r == 31'd0) ? 31'd1 : own_mass_r;
  assign en       = !b_v_r;
  assign in_ready = en;

  icr_div #(
    .NUM_W (47),
    .DEN_W (32),
    .QW    (WDIV_QW),
    .BPS   (WDIV_BPS)
  ) u_wdiv (
    .clk (clk),
    .en  (en),
    .num ({st_r[0].m2, 16'd0}),
    .den ({1'b0, m1} + {1'b0, st_r[0].m2}),
    .quo (wq),
    .rem (wrem)
  );

  for (genvar c = 0; c < 3; c++) begin : g_fdiv
    icr_div #(
      .NUM_W (80),
      .DEN_W (31),
      .QW    (FDIV_QW),
      .BPS   (FDIV_BPS)
    ) u_div1 (
      .clk (clk),
      .en  (en),
      .num (st_r[ST_FEED].num1[c]),
      .den (m1),
      .quo (q1[c]),
      .rem ()
    );
    icr_div #(
      .NUM_W (80),
      .DEN_W (31),
      .QW    (FDIV_QW),
      .BPS   (FDIV_BPS)
    ) u_div2 (
      .clk (clk),
      .en  (en),
      .num (st_r[ST_FEED].num2[c]),
      .den (st_r[ST_FEED].m2),
      .quo (q2[c]),
      .rem ()
    );
  end

  always_comb begin
    logic [31:0] nm;
    logic [32:0] rm;
    logic [64:0] p65;
    logic [48:0] sh49;
    logic [62:0] pp;
    logic [46:0] pm;
    logic [49:0] vm;
    logic [17:0] onee;
    logic [67:0] kp;
    logic [51:0] km;
    logic [81:0] s82;
    logic [63:0] tm;
    logic [80:0] s81;
    logic [63:0] fm;
    logic [15:0] w1;
    logic [16:0] w2;
    logic [67:0] dp1;
    logic [68:0] dp2;
    logic [51:0] dm;
    logic [83:0] s84;
    icr_pkg::s64_t ue;
    icr_pkg::s64_t pe;

    st_nxt[0] = st_r[0];
    for (int s = 1; s < NSTG; s++) st_nxt[s] = st_r[s-1];

    // capture, relative velocity
    st_nxt[0].go = own_dyn_r & in_peer_is_static;
    st_nxt[0].m2 = (in_peer_mass == 31'd0) ? 31'd1 : in_peer_mass;
    st_nxt[0].n[0] = in_normal_x;
    st_nxt[0].n[1] = in_normal_y;
    st_nxt[0].n[2] = in_normal_z;
    st_nxt[0].u[0] = in_own_vel_x;
    st_nxt[0].u[1] = in_own_vel_y;
    st_nxt[0].u[2] = in_own_vel_z;
    st_nxt[0].p[0] = in_peer_vel_x;
    st_nxt[0].p[1] = in_peer_vel_y;
    st_nxt[0].p[2] = in_peer_vel_z;
    for (int i = 0; i < 3; i++) begin
      st_nxt[0].r[i] = {st_nxt[0].u[i][31], st_nxt[0].u[i]}
                     - {st_nxt[0].p[i][31], st_nxt[0].p[i]};
    end

    // n * r products and push
    for (int i = 0; i < 3; i++) begin
      nm   = abs32(st_r[0].n[i]);
      rm   = st_r[0].r[i][32] ? (~st_r[0].r[i] + 33'd1) : st_r[0].r[i];
      p65  = {33'd0, nm} * {32'd0, rm};
      sh49 = p65[64:16];
      st_nxt[1].a[i] = (st_r[0].n[i][31] ^ st_r[0].r[i][32]) ? -{1'b0, sh49}
                                                             : {1'b0, sh49};
      pp = {31'd0, nm} * {32'd0, sep_r};
      pm = pp[62:16];
      if (st_r[0].n[i][31]) begin
        st_nxt[1].push[i] = (pm > 47'h0000_8000_0000) ? 32'h8000_0000 : -pm[31:0];
      end else begin
        st_nxt[1].push[i] = (pm > 47'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : pm[31:0];
      end
    end

    // normal velocity
    st_nxt[2].vn = {st_r[1].a[0][49], st_r[1].a[0]} + {st_r[1].a[1][49], st_r[1].a[1]}
                 + {st_r[1].a[2][49], st_r[1].a[2]};

    // impulse scale and n * vn partial products
    vm   = st_r[2].vn[50] ? 50'(~st_r[2].vn + 51'd1) : st_r[2].vn[49:0];
    onee = 18'd65536 + {1'b0, rest_r};
    kp   = {18'd0, vm} * {50'd0, onee};
    km   = kp[67:16];
    st_nxt[3].k = st_r[2].vn[50] ? km : -km;
    for (int i = 0; i < 3; i++) begin
      nm = abs32(st_r[2].n[i]);
      st_nxt[3].nvlo[i]  = {32'd0, nm} * {32'd0, vm[31:0]};
      st_nxt[3].nvhi[i]  = {18'd0, nm} * {32'd0, vm[49:32]};
      st_nxt[3].nvneg[i] = st_r[2].n[i][31] ^ st_r[2].vn[50];
    end

    for (int i = 0; i < 3; i++) begin
      s82 = {st_r[3].nvhi[i], 32'd0} + {18'd0, st_r[3].nvlo[i]};
      st_nxt[4].nvn[i] = from_mag(st_r[3].nvneg[i], {14'd0, s82[81:16]});
    end

    // tangent
    for (int i = 0; i < 3; i++) begin
      st_nxt[5].t[i] = ssub({{31{st_r[4].r[i][32]}}, st_r[4].r[i]}, st_r[4].nvn[i]);
    end

    // friction partial products
    st_nxt[6].tz = (st_r[5].t[0] == 64'sd0) && (st_r[5].t[1] == 64'sd0)
                && (st_r[5].t[2] == 64'sd0);
    for (int i = 0; i < 3; i++) begin
      tm = mag64(st_r[5].t[i]);
      st_nxt[6].flo[i]  = {17'd0, tm[31:0]} * {32'd0, fric_r};
      st_nxt[6].fhi[i]  = {17'd0, tm[63:32]} * {32'd0, fric_r};
      st_nxt[6].fneg[i] = st_r[5].t[i][63];
    end

    for (int i = 0; i < 3; i++) begin
      s81 = {st_r[6].fhi[i], 32'd0} + {32'd0, st_r[6].flo[i]};
      st_nxt[7].f[i] = from_mag(st_r[6].fneg[i], {15'd0, s81[80:16]});
    end

    // divider feed, overflow when the quotient reaches 2^63
    for (int i = 0; i < 3; i++) begin
      fm = mag64(st_r[7].f[i]);
      st_nxt[8].fneg[i] = st_r[7].f[i][63];
      st_nxt[8].ovf1[i] = {14'd0, fm} >= {m1, 47'd0};
      st_nxt[8].ovf2[i] = {14'd0, fm} >= {st_r[7].m2, 47'd0};
      st_nxt[8].num1[i] = st_nxt[8].ovf1[i] ? 80'd0 : {fm, 16'd0};
      st_nxt[8].num2[i] = st_nxt[8].ovf2[i] ? 80'd0 : {fm, 16'd0};
    end

    // mass shares and per-body impulse
    w1  = wq;
    w2  = 17'd65536 - {1'b0, w1} - {16'd0, (wrem != 32'd0)};
    km  = st_r[ST_FEED].k[51] ? (~st_r[ST_FEED].k + 52'd1) : st_r[ST_FEED].k;
    dp1 = {16'd0, km} * {52'd0, w1};
    dp2 = {17'd0, km} * {52'd0, w2};
    st_nxt[ST_FEED+1].d1 = st_r[ST_FEED].k[51] ? -dp1[67:16] : dp1[67:16];
    st_nxt[ST_FEED+1].d2 = st_r[ST_FEED].k[51] ? -dp2[67:16] : dp2[67:16];

    for (int i = 0; i < 3; i++) begin
      nm = abs32(st_r[ST_FEED+1].n[i]);
      dm = st_r[ST_FEED+1].d1[51] ? (~st_r[ST_FEED+1].d1 + 52'd1) : st_r[ST_FEED+1].d1;
      st_nxt[ST_FEED+2].nd1lo[i] = {32'd0, nm} * {32'd0, dm[31:0]};
      st_nxt[ST_FEED+2].nd1hi[i] = {20'd0, nm} * {32'd0, dm[51:32]};
      st_nxt[ST_FEED+2].nd1ng[i] = st_r[ST_FEED+1].n[i][31] ^ st_r[ST_FEED+1].d1[51];
      dm = st_r[ST_FEED+1].d2[51] ? (~st_r[ST_FEED+1].d2 + 52'd1) : st_r[ST_FEED+1].d2;
      st_nxt[ST_FEED+2].nd2lo[i] = {32'd0, nm} * {32'd0, dm[31:0]};
      st_nxt[ST_FEED+2].nd2hi[i] = {20'd0, nm} * {32'd0, dm[51:32]};
      st_nxt[ST_FEED+2].nd2ng[i] = st_r[ST_FEED+1].n[i][31] ^ st_r[ST_FEED+1].d2[51];
    end

    for (int i = 0; i < 3; i++) begin
      s84 = {st_r[ST_FEED+2].nd1hi[i], 32'd0} + {20'd0, st_r[ST_FEED+2].nd1lo[i]};
      st_nxt[ST_FEED+3].nd1[i] = from_mag(st_r[ST_FEED+2].nd1ng[i], {12'd0, s84[83:16]});
      s84 = {st_r[ST_FEED+2].nd2hi[i], 32'd0} + {20'd0, st_r[ST_FEED+2].nd2lo[i]};
      st_nxt[ST_FEED+3].nd2[i] = from_mag(st_r[ST_FEED+2].nd2ng[i], {12'd0, s84[83:16]});
    end

    for (int i = 0; i < 3; i++) begin
      st_nxt[ST_FEED+4].u1[i] = sadd({{32{st_r[ST_FEED+3].u[i][31]}}, st_r[ST_FEED+3].u[i]},
                                     st_r[ST_FEED+3].nd1[i]);
      st_nxt[ST_FEED+4].p1[i] = ssub({{32{st_r[ST_FEED+3].p[i][31]}}, st_r[ST_FEED+3].p[i]},
                                     st_r[ST_FEED+3].nd2[i]);
    end

    // friction velocity change from the dividers
    for (int i = 0; i < 3; i++) begin
      st_nxt[ST_FDONE+1].fd1[i] = from_mag(st_r[ST_FDONE].fneg[i],
                                  st_r[ST_FDONE].ovf1[i] ? MAG_LIM : {17'd0, q1[i]});
      st_nxt[ST_FDONE+1].fd2[i] = from_mag(st_r[ST_FDONE].fneg[i],
                                  st_r[ST_FDONE].ovf2[i] ? MAG_LIM : {17'd0, q2[i]});
    end

    // result
    res.resolved = st_r[NSTG-1].go;
    for (int i = 0; i < 3; i++) begin
      ue = st_r[NSTG-1].tz ? st_r[NSTG-1].u1[i]
                           : ssub(st_r[NSTG-1].u1[i], st_r[NSTG-1].fd1[i]);
      pe = st_r[NSTG-1].tz ? st_r[NSTG-1].p1[i]
                           : sadd(st_r[NSTG-1].p1[i], st_r[NSTG-1].fd2[i]);
      if (st_r[NSTG-1].go) begin
        res.own[i]  = clamp32(ue);
        res.peer[i] = clamp32(pe);
        res.push[i] = st_r[NSTG-1].push[i];
      end else begin
        res.own[i]  = st_r[NSTG-1].u[i];
        res.peer[i] = st_r[NSTG-1].p[i];
        res.push[i] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mass_r <= icr_pkg::OWN_MASS_RST;
      own_dyn_r  <= 1'b1;
      rest_r     <= icr_pkg::REST_RST;
      fric_r     <= icr_pkg::FRIC_RST;
      sep_r      <= icr_pkg::SEP_RST;
      v_r        <= '0;
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          icr_pkg::REG_OWN_MASS: own_mass_r <= cfg_data;
          icr_pkg::REG_OWN_DYN:  own_dyn_r  <= cfg_data[0];
          icr_pkg::REG_REST:     rest_r     <= cfg_data[16:0];
          icr_pkg::REG_FRIC:     fric_r     <= cfg_data[16:0];
          icr_pkg::REG_SEP:      sep_r      <= cfg_data;
          default: ;
        endcase
      end
      if (en) v_r <= {v_r[NSTG-2:0], in_valid};
      if (b_v_r) begin
        if (out_ready) b_v_r <= 1'b0;
      end else if (!a_v_r || out_ready) begin
        a_v_r <= v_r[NSTG-1];
      end else if (v_r[NSTG-1]) begin
        b_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSTG; s++) st_r[s] <= st_nxt[s];
    end
    if (b_v_r) begin
      if (out_ready) a_r <= b_r;
    end else if (!a_v_r || out_ready) begin
      a_r <= res;
    end else begin
      b_r <= res;
    end
  end

  assign out_valid          = a_v_r;
  assign out_new_own_vel_x  = a_r.own[0];
  assign out_new_own_vel_y  = a_r.own[1];
  assign out_new_own_vel_z  = a_r.own[2];
  assign out_new_peer_vel_x = a_r.peer[0];
  assign out_new_peer_vel_y = a_r.peer[1];
  assign out_new_peer_vel_z = a_r.peer[2];
  assign out_push_x         = a_r.push[0];
  assign out_push_y         = a_r.push[1];
  assign out_push_z         = a_r.push[2];
  assign out_resolved       = a_r.resolved;

endmodule

### hdl/icr_check.sv
// ----------------------------------------------------------------------------
// icr_check
// Port-level checks on the collision response block, bound to its top level.
// ----------------------------------------------------------------------------
module icr_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_own_vel_x,
  input logic [31:0] out_push_x,
  input logic [31:0] out_push_y,
  input logic [31:0] out_push_z,
  input logic        out_resolved
);

  // input only held off while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a taken result frees the skid slot
  a_stall_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready && out_ready) |=> in_ready)
    else $error("input still stalled after result taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_own_vel_x)
                                   && $stable(out_resolved)))
    else $error("result changed while stalled");

  // unresolved contacts carry no push
  a_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_resolved) |->
      (out_push_x == 32'd0 && out_push_y == 32'd0 && out_push_z == 32'd0))
    else $error("push on unresolved item");

endmodule

bind impulse_collision_response icr_check u_icr_check (.*);

### bench/tb_impulse_collision_response.sv
// ----------------------------------------------------------------------------
// tb_impulse_collision_response
// Self-checking bench for the contact resolver. Drives contacts with random
// gaps and output stalls and predicts every result in Q16.16 with saturation.
// The register settings run from reset values through to the extremes.
// ----------------------------------------------------------------------------
module tb_impulse_collision_response;
  import icr_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;
  localparam logic signed [63:0] S64_MAX = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

  typedef struct {
    logic signed [31:0] n [3];
    logic signed [31:0] u [3];
    logic signed [31:0] p [3];
    logic [30:0]        m2;
    logic               st;
  } contact_t;

  typedef struct {
    logic signed [31:0] own  [3];
    logic signed [31:0] peer [3];
    logic signed [31:0] push [3];
    logic               resolved;
  } response_t;

  function automatic logic [63:0] mag64(logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic signed [63:0] signed_of(logic neg, logic [63:0] m);
    if (neg) return m[63] ? S64_MIN : -$signed(m);
    return m[63] ? S64_MAX : $signed(m);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] pr;
    logic [63:0]  lo;
    pr = ({64'd0, mag64(a)} * {64'd0, mag64(b)}) >> FRAC_BITS;
    lo = (pr[127:64] != 0) ? '1 : pr[63:0];
    return signed_of(a[63] ^ b[63], lo);
  endfunction

  function automatic logic [63:0] fx_udiv(logic [63:0] num, logic [63:0] den);
    logic [79:0] q;
    if (((num / den) >> (63 - FRAC_BITS)) != 0) return 64'h8000000000000000;
    q = {num, 16'd0} / {16'd0, den};
    return q[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  class contact_scoreboard;
    logic [30:0] own_mass = OWN_MASS_RST;
    logic        own_dyn  = 1'b1;
    logic [16:0] rest     = REST_RST;
    logic [16:0] fric     = FRIC_RST;
    logic [30:0] sep      = SEP_RST;
    response_t   pending_q[$];
    int          errors = 0;

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [30:0] d);
      case (idx)
        REG_OWN_MASS: own_mass = d;
        REG_OWN_DYN:  own_dyn  = d[0];
        REG_REST:     rest     = d[16:0];
        REG_FRIC:     fric     = d[16:0];
        REG_SEP:      sep      = d;
        default: ;
      endcase
    endfunction

    function response_t resolve(contact_t c);
      response_t res;
      logic signed [63:0] u [3], p [3], r [3], t [3], push [3];
      logic signed [63:0] vn, k, d1, d2, w1, w2, f;
      logic [63:0] m1, m2;
      logic go, tz;
      go = own_dyn && c.st;
      m1 = (own_mass == 0) ? 64'd1 : {33'd0, own_mass};
      m2 = (c.m2 == 0) ? 64'd1 : {33'd0, c.m2};
      for (int i = 0; i < 3; i++) begin
        u[i] = c.u[i];
        p[i] = c.p[i];
        push[i] = 0;
      end
      if (go) begin
        vn = 0;
        tz = 1'b1;
        w1 = fx_udiv(m2, m1 + m2);
        w2 = fx_udiv(m1, m1 + m2);
        for (int i = 0; i < 3; i++) begin
          r[i] = sub_sat(u[i], p[i]);
          vn = add_sat(vn, fx_mul(c.n[i], r[i]));
        end
        k = fx_mul(64'sd65536 + rest, vn);
        k = (k == S64_MIN) ? S64_MAX : -k;
        d1 = fx_mul(k, w1);
        d2 = fx_mul(k, w2);
        for (int i = 0; i < 3; i++) begin
          u[i] = add_sat(u[i], fx_mul(c.n[i], d1));
          p[i] = sub_sat(p[i], fx_mul(c.n[i], d2));
          t[i] = sub_sat(r[i], fx_mul(c.n[i], vn));
          if (t[i] != 0) tz = 1'b0;
        end
        if (!tz) begin
          for (int i = 0; i < 3; i++) begin
            f = fx_mul(t[i], {47'd0, fric});
            u[i] = sub_sat(u[i], signed_of(f[63], fx_udiv(mag64(f), m1)));
            p[i] = add_sat(p[i], signed_of(f[63], fx_udiv(mag64(f), m2)));
          end
        end
        for (int i = 0; i < 3; i++) push[i] = fx_mul(c.n[i], {33'd0, sep});
      end
      for (int i = 0; i < 3; i++) begin
        res.own[i]  = clamp32(u[i]);
        res.peer[i] = clamp32(p[i]);
        res.push[i] = clamp32(push[i]);
      end
      res.resolved = go;
      return res;
    endfunction

    function void note_contact(contact_t c);
      pending_q.push_back(resolve(c));
    endfunction

    function void check_response(response_t got);
      response_t exp;
      logic bad;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response, nothing pending");
        return;
      end
      exp = pending_q.pop_front();
      bad = (got.resolved !== exp.resolved);
      for (int i = 0; i < 3; i++)
        if (got.own[i] !== exp.own[i] || got.peer[i] !== exp.peer[i] ||
            got.push[i] !== exp.push[i]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp own %0d %0d %0d peer %0d %0d %0d push %0d %0d %0d res %0d",
                   exp.own[0], exp.own[1], exp.own[2], exp.peer[0], exp.peer[1],
                   exp.peer[2], exp.push[0], exp.push[1], exp.push[2], exp.resolved,
                   "\n          got own %0d %0d %0d peer %0d %0d %0d push %0d %0d %0d res %0d",
                   got.own[0], got.own[1], got.own[2], got.peer[0], got.peer[1],
                   got.peer[2], got.push[0], got.push[1], got.push[2], got.resolved);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_n [3] = '{0, 0, 0};
  logic signed [31:0] in_u [3] = '{0, 0, 0};
  logic signed [31:0] in_p [3] = '{0, 0, 0};
  logic [30:0] in_peer_mass = '0;
  logic in_peer_is_static = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] o_own [3], o_peer [3], o_push [3];
  logic out_resolved;

  contact_scoreboard sb = new();
  bit idle_on = 1'b0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;

  impulse_collision_response DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_normal_x(in_n[0]), .in_normal_y(in_n[1]), .in_normal_z(in_n[2]),
    .in_own_vel_x(in_u[0]), .in_own_vel_y(in_u[1]), .in_own_vel_z(in_u[2]),
    .in_peer_vel_x(in_p[0]), .in_peer_vel_y(in_p[1]), .in_peer_vel_z(in_p[2]),
    .in_peer_mass(in_peer_mass), .in_peer_is_static(in_peer_is_static),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_own_vel_x(o_own[0]), .out_new_own_vel_y(o_own[1]),
    .out_new_own_vel_z(o_own[2]),
    .out_new_peer_vel_x(o_peer[0]), .out_new_peer_vel_y(o_peer[1]),
    .out_new_peer_vel_z(o_peer[2]),
    .out_push_x(o_push[0]), .out_push_y(o_push[1]), .out_push_z(o_push[2]),
    .out_resolved(out_resolved)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    response_t got;
    if (out_valid && out_ready) begin
      for (int i = 0; i < 3; i++) begin
        got.own[i]  = o_own[i];
        got.peer[i] = o_peer[i];
        got.push[i] = o_push[i];
      end
      got.resolved = out_resolved;
      sb.check_response(got);
    end
    if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("tb_impulse_collision_response NOT OK");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [30:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_contact(contact_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_n <= c.n;
    in_u <= c.u;
    in_p <= c.p;
    in_peer_mass <= c.m2;
    in_peer_is_static <= c.st;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_contact(c);
  endtask

  function automatic logic signed [31:0] rand_vel();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 4) c.n[i] = 0;
      else if (kind < 8) c.n[i] = $signed($urandom_range(0, 92682)) - 46341;
      else c.n[i] = $urandom;
      c.u[i] = rand_vel();
      c.p[i] = rand_vel();
    end
    if (kind < 4) c.n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 65536 : -65536;
    case ($urandom_range(0, 9))
      0: c.m2 = 0;
      1: c.m2 = 31'h7fffffff;
      2: c.m2 = $urandom;
      default: c.m2 = $urandom_range(1, 32'h0040_0000);
    endcase
    c.st = ($urandom_range(0, 6) != 0);
    return c;
  endfunction

  function automatic contact_t make_contact(int nx, int ny, int nz, int ux, int uy, int uz,
                                            int px, int py, int pz, int m, bit st);
    contact_t c;
    c.n = '{nx, ny, nz};
    c.u = '{ux, uy, uz};
    c.p = '{px, py, pz};
    c.m2 = m;
    c.st = st;
    return c;
  endfunction

  initial begin
    contact_t d [$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed contacts at reset settings
    d.push_back(make_contact(65536, 0, 0, -65536, 0, 0, 0, 0, 0, 65536, 1));
    d.push_back(make_contact(0, 65536, 0, 100000, -200000, 300, 5, 6, 7, 65536, 1));
    d.push_back(make_contact(0, 0, -65536, 1, 2, 3, 4, 5, 6, 131072, 0));
    d.push_back(make_contact(65536, 0, 0, 300000, 0, 0, -5000, 0, 0, 65536, 1));
    d.push_back(make_contact(46341, 46341, 0, 70000, -9000, 12345, 0, 0, 0, 1, 1));
    d.push_back(make_contact(0, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 1));
    d.push_back(make_contact(0, -65536, 0, 2147483647, -2147483648, 2147483647,
                             -2147483648, 2147483647, -2147483648, 2147483647, 1));
    d.push_back(make_contact(-2147483648, -2147483648, -2147483648, 2147483647,
                             2147483647, 2147483647, -2147483648, -2147483648,
                             -2147483648, 1, 1));
    d.push_back(make_contact(2147483647, 2147483647, 2147483647, -2147483648, 0,
                             2147483647, 0, -1, 0, 2147483647, 1));
    d.push_back(make_contact(131072, 0, 0, 65536, 65536, 0, 0, 0, 0, 65536, 1));
    d.push_back(make_contact(-1, -1, -1, -1, -1, -1, -1, -1, -1, 2147483647, 0));
    d.push_back(make_contact(0, 0, 0, 12345, 6789, -4321, 1, 2, 3, 65536, 1));
    d.push_back(make_contact(65536, 0, 0, -100, 500000, -500000, 0, 0, 0, 0, 1));
    foreach (d[i]) send_contact(d[i]);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: ;
        1: begin
          write_reg(REG_OWN_MASS, 1);
          write_reg(REG_REST, 0);
          write_reg(REG_FRIC, 0);
          write_reg(REG_SEP, 0);
        end
        2: begin
          write_reg(REG_OWN_MASS, 31'h7fffffff);
          write_reg(REG_REST, 65536);
          write_reg(REG_FRIC, 65536);
          write_reg(REG_SEP, 31'h7fffffff);
        end
        3: begin
          write_reg(REG_OWN_MASS, 0);
          write_reg(REG_REST, 31'h1ffff);
          write_reg(REG_FRIC, 31'h7fffffff);
          write_reg(REG_SEP, 65536);
        end
        4: begin
          write_reg(REG_OWN_DYN, 0);
          write_reg(REG_OWN_MASS, 65536);
        end
        5: begin
          write_reg(REG_OWN_DYN, 31'h7ffffffe);
          write_reg(REG_SPARE, 31'h5555);
          write_reg(REG_OWN_DYN, 1);
          write_reg(REG_OWN_MASS, $urandom);
          write_reg(REG_REST, $urandom_range(0, 65536));
          write_reg(REG_FRIC, $urandom_range(0, 65536));
          write_reg(REG_SEP, $urandom_range(0, 655360));
        end
        default: begin
          write_reg(REG_OWN_MASS, $urandom_range(1, 32'h0040_0000));
          write_reg(REG_REST, $urandom_range(0, 65536));
          write_reg(REG_FRIC, $urandom_range(0, 65536));
          write_reg(REG_SEP, $urandom);
        end
      endcase
      cfg_we <= 1'b0;
      idle_on = (phase % 3 != 1);
      if (phase == 2) long_hold = 1'b1;
      for (int i = 0; i < 215; i++) begin
        if (phase == 3 && i == 100) settle();
        send_contact(rand_contact());
      end
    end

    settle();
    if (sb.errors == 0) $display("tb_impulse_collision_response OK");
    else $display("tb_impulse_collision_response NOT OK");
    $finish;
  end

endmodule
